[rtl/core/sst_pkg.sv]
// ----------------------------------------------------------------------------
// sst_pkg: shared types and constants of the tone oscillator
// Request and result payloads, configuration write bundle, command codes
// and the back-end state encoding.
// ----------------------------------------------------------------------------
package sst_pkg;

  // Widths of the fixed payload fields and registers.
  localparam int unsigned FieldW   = 16;
  localparam int unsigned CfgDataW = 17;
  localparam int unsigned VolW     = 16;
  localparam int unsigned DutyW    = 17;
  localparam int unsigned RomW     = 15;
  localparam int unsigned DutyShift = 16;
  localparam int unsigned VolShift  = 15;

  // Full-scale values and reset values of the registers.
  localparam logic [VolW-1:0]   VolFull          = 16'd32768;
  localparam logic [DutyW-1:0]  DutyFull         = 17'd65536;
  localparam logic [VolW-1:0]   VolumeReset      = 16'd32768;
  localparam logic [DutyW-1:0]  DutyReset        = 17'd32768;
  localparam logic [FieldW-1:0] StartPeriodReset = 16'd100;

  typedef enum logic {
    OP_TICK   = 1'b0,
    OP_RETUNE = 1'b1
  } opcode_e;

  typedef enum logic {
    WAVE_SINE   = 1'b0,
    WAVE_SQUARE = 1'b1
  } wave_e;

  typedef enum logic [1:0] {
    REG_WAVE_SELECT  = 2'd0,
    REG_VOLUME       = 2'd1,
    REG_DUTY         = 2'd2,
    REG_START_PERIOD = 2'd3
  } cfg_reg_e;

  // Command classes handed from the front end to the back end.
  typedef enum logic [1:0] {
    CMD_TICK   = 2'd0,
    CMD_RETUNE = 2'd1,
    CMD_REJECT = 2'd2
  } cmd_e;

  typedef enum logic [3:0] {
    BK_INIT,
    BK_IDLE,
    BK_TICK,
    BK_DIV,
    BK_ROM,
    BK_MUL,
    BK_SIGN,
    BK_RT_MUL,
    BK_RT_DIV,
    BK_EMIT
  } bk_state_e;

  typedef struct packed {
    opcode_e           opcode;
    logic [FieldW-1:0] target_period;
  } in_req_t;

  typedef struct packed {
    logic signed [FieldW-1:0] sample;
    logic [FieldW-1:0]        phase_used;
    logic                     retune_error;
  } out_rsp_t;

  typedef struct packed {
    logic                we;
    cfg_reg_e            idx;
    logic [CfgDataW-1:0] data;
  } cfg_wr_t;

endpackage

[rtl/core/sst_ram.sv]
// ----------------------------------------------------------------------------
// sst_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module sst_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/sst_div.sv]
// ----------------------------------------------------------------------------
// sst_div: restoring radix-2 divider
// Starts from a partial remainder below the divisor and shifts in one
// dividend bit per cycle, producing one quotient bit per cycle.
// ----------------------------------------------------------------------------
module sst_div #(
  parameter int unsigned Width    = 16,
  parameter int unsigned QuoWidth = 16,
  parameter int unsigned CntWidth = 5
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [Width-1:0]    rem_i,
  input  logic [Width-1:0]    shift_i,
  input  logic [Width-1:0]    divisor_i,
  input  logic [CntWidth-1:0] steps_i,
  output logic                done_o,
  output logic [QuoWidth-1:0] quo_o
);

  logic [Width-1:0]    rem_q, rem_d;
  logic [Width-1:0]    shift_q, shift_d;
  logic [Width-1:0]    dvsr_q, dvsr_d;
  logic [QuoWidth-1:0] quo_q, quo_d;
  logic [CntWidth-1:0] cnt_q, cnt_d;
  logic                done_q, done_d;
  logic [Width:0]      trial;
  logic [Width:0]      diff;
  logic                ge;

  // Trial subtraction: the borrow bit tells whether the divisor fits.
  assign trial = {rem_q, shift_q[Width-1]};
  assign diff  = trial - {1'b0, dvsr_q};
  assign ge    = ~diff[Width];

  // One quotient bit per cycle while steps remain.
  always_comb begin
    rem_d   = rem_q;
    shift_d = shift_q;
    dvsr_d  = dvsr_q;
    quo_d   = quo_q;
    cnt_d   = cnt_q;
    done_d  = 1'b0;
    if (start_i) begin
      rem_d   = rem_i;
      shift_d = shift_i;
      dvsr_d  = divisor_i;
      quo_d   = '0;
      cnt_d   = steps_i;
    end else if (cnt_q != '0) begin
      rem_d   = ge ? diff[Width-1:0] : trial[Width-1:0];
      shift_d = shift_q << 1;
      quo_d   = {quo_q[QuoWidth-2:0], ge};
      cnt_d   = cnt_q - CntWidth'(1);
      done_d  = (cnt_q == CntWidth'(1));
    end
  end

  // Step counter and done flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    rem_q   <= rem_d;
    shift_q <= shift_d;
    dvsr_q  <= dvsr_d;
    quo_q   <= quo_d;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

[rtl/core/sst_front.sv]
// ----------------------------------------------------------------------------
// sst_front: request intake and classification
// Accepts requests, sorts them into tick, retune and rejected retune, and
// holds them in a two-entry command queue for the back end.
// ----------------------------------------------------------------------------
module sst_front import sst_pkg::*; #(
  parameter int unsigned PERIOD_BITS = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   init_done_i,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  in_req_t                in_req_i,
  output logic                   cmd_valid_o,
  output cmd_e                   cmd_kind_o,
  output logic [PERIOD_BITS-1:0] cmd_np_o,
  input  logic                   cmd_pop_i
);

  localparam int unsigned QueueDepth = 2;
  localparam int unsigned PtrW       = $clog2(QueueDepth);
  localparam int unsigned CntW       = $clog2(QueueDepth + 1);

  cmd_e                   kind_q [QueueDepth];
  logic [PERIOD_BITS-1:0] np_q   [QueueDepth];
  logic [PtrW-1:0]        wr_q, wr_d;
  logic [PtrW-1:0]        rd_q, rd_d;
  logic [CntW-1:0]        cnt_q, cnt_d;
  logic [PERIOD_BITS-1:0] np_in;
  cmd_e                   kind_in;
  logic                   push;

  // The new period is cut to the period width before the zero check.
  assign np_in = PERIOD_BITS'(in_req_i.target_period);

  always_comb begin
    case (in_req_i.opcode)
      OP_TICK:   kind_in = CMD_TICK;
      OP_RETUNE: kind_in = (np_in == '0) ? CMD_REJECT : CMD_RETUNE;
      default:   kind_in = CMD_TICK;
    endcase
  end

  // Queue handshake.
  assign in_ready_o  = init_done_i && (cnt_q != CntW'(QueueDepth));
  assign push        = in_valid_i && in_ready_o;
  assign cmd_valid_o = (cnt_q != '0);
  assign cmd_kind_o  = kind_q[rd_q];
  assign cmd_np_o    = np_q[rd_q];

  // Pointer and fill count update.
  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push) begin
      wr_d = wr_q + PtrW'(1);
    end
    if (cmd_pop_i) begin
      rd_d = rd_q + PtrW'(1);
    end
    case ({push, cmd_pop_i})
      2'b10:   cnt_d = cnt_q + CntW'(1);
      2'b01:   cnt_d = cnt_q - CntW'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Queue storage.
  always_ff @(posedge clk_i) begin
    if (push) begin
      kind_q[wr_q] <= kind_in;
      np_q[wr_q]   <= np_in;
    end
  end

`ifndef ASSERT_OFF
  // The back end must never take a command from an empty queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop_i |-> (cnt_q != '0))
    else $error("command popped from empty queue");
`endif

endmodule

[rtl/core/sst_back.sv]
// ----------------------------------------------------------------------------
// sst_back: oscillator state and sample generation
// Holds phase, period and duty threshold, runs sine ticks and retunes through a
// shared divider, reads the quarter-wave ROM and drives the result register.
// ----------------------------------------------------------------------------
module sst_back import sst_pkg::*; #(
  parameter int unsigned PERIOD_BITS     = 16,
  parameter int unsigned SINE_TABLE_BITS = 10
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  cfg_wr_t                cfg_i,
  input  logic                   cmd_valid_i,
  input  cmd_e                   cmd_kind_i,
  input  logic [PERIOD_BITS-1:0] cmd_np_i,
  output logic                   cmd_pop_o,
  output logic                   init_done_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output out_rsp_t               out_rsp_o
);

  localparam int unsigned PB       = PERIOD_BITS;
  localparam int unsigned TB       = SINE_TABLE_BITS;
  localparam int unsigned QSteps   = 1 << TB;
  localparam int unsigned RomDepth = QSteps + 1;
  localparam int unsigned AW       = $clog2(RomDepth);
  localparam int unsigned QuoW     = (PB > TB + 2) ? PB : TB + 2;
  localparam int unsigned CntW     = $clog2(QuoW + 1);
  localparam int unsigned ProdW    = VolW + RomW;

  localparam logic [PB-1:0] PeriodReset = PB'(StartPeriodReset);
  localparam logic [PB-1:0] DthrReset   =
    PB'((int'(DutyReset) * int'(StartPeriodReset)) >> DutyShift);

  // Quarter-wave image: sine from a Q30 Taylor series, rounded to Q15.
  localparam logic [63:0] HalfPiQ30 = 64'd1686629713;
  localparam logic [63:0] TaylorDiv [8] = '{
    64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272
  };

  typedef logic [RomW-1:0] rom_image_t [RomDepth];

  function automatic rom_image_t build_rom_image();
    rom_image_t         img;
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic [63:0]        v;
    logic signed [63:0] acc;
    int                 i;
    int                 k;
    for (i = 0; i < RomDepth; i++) begin
      x    = (HalfPiQ30 * 64'(i)) >> TB;
      x2   = (x * x) >> 30;
      term = x;
      acc  = $signed(x);
      for (k = 0; k < 8; k++) begin
        term = ((term * x2) >> 30) / TaylorDiv[k];
        if ((k & 1) == 0) begin
          acc = acc - $signed(term);
        end else begin
          acc = acc + $signed(term);
        end
      end
      if (acc < 0) begin
        acc = '0;
      end
      v = ($unsigned(acc) * 64'd32767 + (64'd1 << 29)) >> 30;
      if (v > 64'd32767) begin
        v = 64'd32767;
      end
      img[i] = RomW'(v);
    end
    return img;
  endfunction

  localparam rom_image_t RomImage = build_rom_image();

  bk_state_e         state_q, state_d;
  logic [PB-1:0]     phase_q, phase_d;
  logic [PB-1:0]     period_q, period_d;
  logic [PB-1:0]     dthr_q;
  wave_e             wave_q, wave_d;
  logic [VolW-1:0]   vol_q, vol_d;
  logic [DutyW-1:0]  duty_q, duty_d;
  logic [AW-1:0]     fill_q, fill_d;
  logic              out_valid_q, out_valid_d;

  logic [PB-1:0]     p_q, p_d;
  logic [PB-1:0]     np_q, np_d;
  logic [2*PB-1:0]   prodrt_q, prodrt_d;
  logic [1:0]        quad_q, quad_d;
  logic [AW-1:0]     idx_q, idx_d;
  logic [ProdW-1:0]  prod_q, prod_d;
  out_rsp_t          res_q, res_d;
  out_rsp_t          out_q, out_d;

  logic [PB-1:0]     p_cur;
  logic [VolW-1:0]   vol_eff;
  logic [DutyW-1:0]  duty_eff;
  logic [DutyW+PB-1:0] dprod;
  logic [FieldW-1:0] sq_high;
  logic [FieldW:0]   sq_low;
  logic [FieldW-1:0] mag;
  logic [AW-1:0]     r_ext;

  logic              div_start;
  logic [PB-1:0]     div_rem;
  logic [PB-1:0]     div_shift;
  logic [CntW-1:0]   div_steps;
  logic              div_done;
  logic [QuoW-1:0]   div_quo;

  logic              ram_we;
  logic [RomW-1:0]   rom_rdata;

  // Shared divider for the angle index and the retune rescale.
  sst_div #(
    .Width    (PB),
    .QuoWidth (QuoW),
    .CntWidth (CntW)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .rem_i     (div_rem),
    .shift_i   (div_shift),
    .divisor_i (period_q),
    .steps_i   (div_steps),
    .done_o    (div_done),
    .quo_o     (div_quo)
  );

  // Quarter-wave ROM, filled by a sweep after reset.
  sst_ram #(
    .Width (RomW),
    .Depth (RomDepth)
  ) u_rom (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (fill_q),
    .wdata_i (RomImage[fill_q]),
    .raddr_i (idx_q),
    .rdata_o (rom_rdata)
  );

  // Saturated gains and the duty threshold product.
  assign vol_eff  = (vol_q > VolFull) ? VolFull : vol_q;
  assign duty_eff = (duty_q > DutyFull) ? DutyFull : duty_q;
  assign dprod    = (DutyW+PB)'(duty_eff) * (DutyW+PB)'(period_q);

  // Square levels: high is floor(vol*32767/32768), low is -vol.
  assign sq_high = vol_eff - ((vol_eff != '0) ? VolW'(1) : VolW'(0));
  assign sq_low  = (FieldW+1)'(0) - {1'b0, vol_eff};
  assign mag     = prod_q[ProdW-1:VolShift];

  // The phase may sit at the period after a wrap; it reads as zero then.
  assign p_cur = (phase_q == period_q) ? '0 : phase_q;
  assign r_ext = {1'b0, div_quo[TB-1:0]};

  // Next state, datapath and configuration writes.
  always_comb begin
    state_d     = state_q;
    phase_d     = phase_q;
    period_d    = period_q;
    wave_d      = wave_q;
    vol_d       = vol_q;
    duty_d      = duty_q;
    fill_d      = fill_q;
    out_valid_d = out_valid_q && !out_ready_i;
    p_d         = p_q;
    np_d        = np_q;
    prodrt_d    = prodrt_q;
    quad_d      = quad_q;
    idx_d       = idx_q;
    prod_d      = prod_q;
    res_d       = res_q;
    out_d       = out_q;
    cmd_pop_o   = 1'b0;
    div_start   = 1'b0;
    div_rem     = '0;
    div_shift   = '0;
    div_steps   = '0;
    ram_we      = 1'b0;

    case (state_q)
      BK_INIT: begin
        ram_we = 1'b1;
        if (fill_q == AW'(QSteps)) begin
          state_d = BK_IDLE;
        end else begin
          fill_d = fill_q + AW'(1);
        end
      end
      BK_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          case (cmd_kind_i)
            CMD_TICK: begin
              p_d     = p_cur;
              phase_d = p_cur + PB'(1);
              state_d = BK_TICK;
            end
            CMD_RETUNE: begin
              np_d     = cmd_np_i;
              prodrt_d = (2*PB)'(phase_q) * (2*PB)'(cmd_np_i);
              state_d  = BK_RT_MUL;
            end
            CMD_REJECT: begin
              res_d.sample       = '0;
              res_d.phase_used   = '0;
              res_d.retune_error = 1'b1;
              state_d            = BK_EMIT;
            end
            default: state_d = BK_IDLE;
          endcase
        end
      end
      BK_TICK: begin
        if (wave_q == WAVE_SQUARE) begin
          res_d.sample       = (p_q < dthr_q) ? $signed(sq_high) : $signed(sq_low[FieldW-1:0]);
          res_d.phase_used   = 16'(p_q);
          res_d.retune_error = 1'b0;
          state_d            = BK_EMIT;
        end else begin
          div_start = 1'b1;
          div_rem   = p_q;
          div_steps = CntW'(TB + 2);
          state_d   = BK_DIV;
        end
      end
      BK_DIV: begin
        if (div_done) begin
          quad_d  = div_quo[TB+1:TB];
          idx_d   = div_quo[TB] ? (AW'(QSteps) - r_ext) : r_ext;
          state_d = BK_ROM;
        end
      end
      BK_ROM: begin
        state_d = BK_MUL;
      end
      BK_MUL: begin
        prod_d  = ProdW'(vol_eff) * ProdW'(rom_rdata);
        state_d = BK_SIGN;
      end
      BK_SIGN: begin
        res_d.sample       = quad_q[1] ? $signed(FieldW'(0) - mag) : $signed(mag);
        res_d.phase_used   = 16'(p_q);
        res_d.retune_error = 1'b0;
        state_d            = BK_EMIT;
      end
      BK_RT_MUL: begin
        div_start = 1'b1;
        div_rem   = prodrt_q[2*PB-1:PB];
        div_shift = prodrt_q[PB-1:0];
        div_steps = CntW'(PB);
        state_d   = BK_RT_DIV;
      end
      BK_RT_DIV: begin
        if (div_done) begin
          phase_d  = div_quo[PB-1:0];
          period_d = np_q;
          state_d  = BK_IDLE;
        end
      end
      BK_EMIT: begin
        if (!out_valid_q || out_ready_i) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase

    // Register writes must arrive only while no request is in flight; the block does not enforce this.
    if (cfg_i.we) begin
      case (cfg_i.idx)
        REG_WAVE_SELECT: wave_d = wave_e'(cfg_i.data[0]);
        REG_VOLUME:      vol_d  = cfg_i.data[VolW-1:0];
        REG_DUTY:        duty_d = cfg_i.data[DutyW-1:0];
        REG_START_PERIOD: begin
          period_d = PB'(cfg_i.data[FieldW-1:0]);
          if (period_d == '0) begin
            period_d = PB'(1);
          end
          phase_d = '0;
        end
        default: wave_d = wave_q;
      endcase
    end
  end

  // Control and oscillator state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_INIT;
      phase_q     <= '0;
      period_q    <= PeriodReset;
      dthr_q      <= DthrReset;
      wave_q      <= WAVE_SINE;
      vol_q       <= VolumeReset;
      duty_q      <= DutyReset;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      period_q    <= period_d;
      dthr_q      <= dprod[DutyShift+PB-1:DutyShift];
      wave_q      <= wave_d;
      vol_q       <= vol_d;
      duty_q      <= duty_d;
      fill_q      <= fill_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    p_q      <= p_d;
    np_q     <= np_d;
    prodrt_q <= prodrt_d;
    quad_q   <= quad_d;
    idx_q    <= idx_d;
    prod_q   <= prod_d;
    res_q    <= res_d;
    out_q    <= out_d;
  end

  assign init_done_o = (state_q != BK_INIT);
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

`ifndef ASSERT_OFF
  // The stored phase never passes the period it runs against.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q <= period_q)
    else $error("phase beyond period");

  // The period stays nonzero so every division is defined.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    period_q != '0)
    else $error("period is zero");

  // A divider result only shows up while the sequencer waits for it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == BK_DIV || state_q == BK_RT_DIV))
    else $error("divider finished outside a wait state");
`endif

endmodule

[rtl/core/sine_square_tone_oscillator.sv]
// ----------------------------------------------------------------------------
// sine_square_tone_oscillator: integer-period sine and square tone generator
// Front end queues tick and retune requests, back end produces samples.
// ----------------------------------------------------------------------------
// A square tick goes through the back-end states TICK and EMIT, a sine tick
// through TICK, DIV, ROM, MUL, SIGN and EMIT, and a rejected retune straight
// to EMIT; a good retune runs RT_MUL and RT_DIV and gives no result.
// One request is in the back end at a time; sine ticks and good retunes use
// the shared radix-2 divider. After reset a ROM fill sweep runs before the
// first request is accepted.
module sine_square_tone_oscillator import sst_pkg::*; #(
  parameter int unsigned PERIOD_BITS     = 16,
  parameter int unsigned SINE_TABLE_BITS = 10
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  in_req_t             in_req_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output out_rsp_t            out_rsp_o,
  input  logic                cfg_we_i,
  input  cfg_reg_e            cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i
);

  cfg_wr_t                cfg;
  logic                   init_done;
  logic                   cmd_valid;
  cmd_e                   cmd_kind;
  logic [PERIOD_BITS-1:0] cmd_np;
  logic                   cmd_pop;

  // Bundle the register write port.
  assign cfg.we   = cfg_we_i;
  assign cfg.idx  = cfg_idx_i;
  assign cfg.data = cfg_wdata_i;

  sst_front #(
    .PERIOD_BITS (PERIOD_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .init_done_i (init_done),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_req_i    (in_req_i),
    .cmd_valid_o (cmd_valid),
    .cmd_kind_o  (cmd_kind),
    .cmd_np_o    (cmd_np),
    .cmd_pop_i   (cmd_pop)
  );

  sst_back #(
    .PERIOD_BITS     (PERIOD_BITS),
    .SINE_TABLE_BITS (SINE_TABLE_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .cmd_valid_i (cmd_valid),
    .cmd_kind_i  (cmd_kind),
    .cmd_np_i    (cmd_np),
    .cmd_pop_o   (cmd_pop),
    .init_done_o (init_done),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_rsp_o   (out_rsp_o)
  );

endmodule
